[src/edff_pkg.sv]
// Shared types, constants and helper functions for the event duplicate filter.
// Used by the history cells, the match reduction tree, the core and its checker.
package edff_pkg;

	localparam int KEY_W             = 120;
	localparam int HISTORY_DEPTH_DEF = 512;
	localparam int TREE_RADIX        = 8;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [31:0]        frame_stamp;
		logic signed [63:0] event_time;
		logic [7:0]         event_kind;
		logic [15:0]        packet_number;
		logic               last_in_log;
	} in_t;

	typedef struct packed {
		logic keep;
		logic log_has_kept;
	} out_t;

	function automatic key_t make_key(input in_t item);
		make_key = {item.event_kind, item.packet_number, item.frame_stamp, item.event_time};
	endfunction

	// Number of registered OR levels needed to fold depth match bits into one.
	function automatic int tree_levels(input int depth);
		int span;
		int lv;
		span = 1;
		lv   = 0;
		while (span < depth) begin
			span = span * TREE_RADIX;
			lv   = lv + 1;
		end
		tree_levels = lv;
	endfunction

endpackage

[src/edff_cell.sv]
// One history cell: holds a key and its valid flag, compares it with an
// incoming key and passes its contents to the next cell. Depends on edff_pkg.
module edff_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmp_en,
	input  edff_pkg::key_t cmp_key,
	input  logic         shift_en,
	input  edff_pkg::key_t key_in,
	input  logic         valid_in,
	output edff_pkg::key_t key_out,
	output logic         valid_out,
	output logic         match
);
	import edff_pkg::*;

	key_t key_q;
	logic valid_q;
	logic match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			key_q <= key_in;
		end
		if (cmp_en) begin
			match_q <= valid_q && (key_q == cmp_key);
		end
	end

	assign key_out   = key_q;
	assign valid_out = valid_q;
	assign match     = match_q;

endmodule

[src/edff_or_tree.sv]
// Registered OR reduction of the per-cell match flags, each radix level registered.
// Depends on edff_pkg for the radix.
module edff_or_tree #(
	parameter int DEPTH  = edff_pkg::HISTORY_DEPTH_DEF,
	parameter int LEVELS = 3
) (
	input  logic             clk,
	input  logic [DEPTH-1:0] leaf,
	output logic             hit
);
	import edff_pkg::*;

	logic [DEPTH-1:0] lvl [0:LEVELS];

	assign lvl[0] = leaf;

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		logic [DEPTH-1:0] nxt;
		logic [DEPTH-1:0] red_q;

		always_comb begin
			nxt = '0;
			for (int j = 0; j < DEPTH; j++) begin
				for (int k = 0; k < TREE_RADIX; k++) begin
					if (j * TREE_RADIX + k < DEPTH) begin
						nxt[j] = nxt[j] | lvl[l-1][j * TREE_RADIX + k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			red_q <= nxt;
		end

		assign lvl[l] = red_q;
	end

	assign hit = lvl[LEVELS][0];

endmodule

[src/event_duplicate_filter_fifo_history_core.sv]
// Top level of the event duplicate filter with a bounded FIFO key history.
// Depends on edff_pkg, edff_cell and edff_or_tree.
// Usage: each input transfer carries one receiver event (in_data). Its frame
// stamp, event time, event kind and packet number form a 120-bit key. Every
// input transfer yields exactly one output transfer (out_data): keep is 1 when
// the key was not in the history, in which case the key enters the history;
// log_has_kept is 1 only on the last event of a log and then reports whether
// any event of that log was kept.
// The history is a row of HISTORY_DEPTH cells that shift by one on each kept
// event; the oldest key drops off the far end once the row is full.
// Timing: the cells compare during the accepting cycle, then the match flags
// pass through L registered OR levels of radix 8, L = ceil(log8(HISTORY_DEPTH)),
// 3 for 512 entries. The result is then decided and committed, and a new event
// is taken only after the previous one has been committed.
// Reset empties the history and clears the open-log flag at once; the block
// takes events from the first cycle after reset.
// When the receiver stalls, the finished result waits in the output register
// and the next event is still taken and searched; it is held before commit
// until the waiting result has been transferred.
module event_duplicate_filter_fifo_history_core #(
	parameter int HISTORY_DEPTH = edff_pkg::HISTORY_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  edff_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output edff_pkg::out_t out_data
);
	import edff_pkg::*;

	localparam int LEVELS   = tree_levels(HISTORY_DEPTH);
	localparam int CNT_W    = $clog2(LEVELS + 2);
	localparam int LAST_CNT = (LEVELS > 0) ? LEVELS - 1 : 0;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REDUCE = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	in_t              item_q;
	logic             kept_log_q;
	logic             out_valid_q;
	out_t             out_q;

	logic             accept;
	logic             commit;
	logic             hit;
	logic             keep;
	key_t             new_key;
	logic [HISTORY_DEPTH-1:0] match;
	key_t             key_chain   [0:HISTORY_DEPTH-1];
	logic             valid_chain [0:HISTORY_DEPTH-1];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign commit   = (state_q == ST_DECIDE) && (!out_valid_q || out_ready);
	assign new_key  = make_key(item_q);
	assign keep     = !hit;

	assign key_chain[0]   = new_key;
	assign valid_chain[0] = 1'b1;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		if (i < HISTORY_DEPTH - 1) begin : g_mid
			edff_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmp_en    (accept),
				.cmp_key   (make_key(in_data)),
				.shift_en  (commit && keep),
				.key_in    (key_chain[i]),
				.valid_in  (valid_chain[i]),
				.key_out   (key_chain[i+1]),
				.valid_out (valid_chain[i+1]),
				.match     (match[i])
			);
		end else begin : g_end
			edff_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmp_en    (accept),
				.cmp_key   (make_key(in_data)),
				.shift_en  (commit && keep),
				.key_in    (key_chain[i]),
				.valid_in  (valid_chain[i]),
				.key_out   (),
				.valid_out (),
				.match     (match[i])
			);
		end
	end

	edff_or_tree #(
		.DEPTH  (HISTORY_DEPTH),
		.LEVELS (LEVELS)
	) u_tree (
		.clk  (clk),
		.leaf (match),
		.hit  (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			kept_log_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= (LEVELS > 0) ? ST_REDUCE : ST_DECIDE;
					end
				end
				ST_REDUCE: begin
					if (cnt_q == CNT_W'(LAST_CNT)) begin
						state_q <= ST_DECIDE;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_DECIDE: begin
					if (commit) begin
						kept_log_q  <= item_q.last_in_log ? 1'b0 : (kept_log_q | keep);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (commit) begin
			out_q.keep         <= keep;
			out_q.log_has_kept <= item_q.last_in_log && (kept_log_q || keep);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[src/edff_checker.sv]
// Port-level checker for the event duplicate filter core, attached by bind.
// Depends on edff_pkg and event_duplicate_filter_fifo_history_core.
module edff_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input edff_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input edff_pkg::out_t out_data
);
	import edff_pkg::*;

	logic in_xfer;

	assign in_xfer = in_valid && in_ready && (in_data.last_in_log || !in_data.last_in_log);

	// A stalled result must be held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or vanished while stalled");

	// The block works on one event at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken again straight after a transfer");

	// A new result only appears out of the commit step, while input is held off.
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a commit step");

	// A result that reports a kept log only appears out of the commit step.
	a_kept_flag_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && out_data.log_has_kept |-> $past(!in_ready, 1))
		else $error("log report outside a commit step");

endmodule

bind event_duplicate_filter_fifo_history_core edff_checker u_edff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[sim/edff_filter_checker.sv]
// Checker for the event duplicate filter: watches both channels, predicts the
// keep and log verdicts from its own copy of the key history and compares them.
// Depends on edff_pkg for the payload types.
module edff_filter_checker #(
	parameter int HISTORY_DEPTH = edff_pkg::HISTORY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  edff_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  edff_pkg::out_t out_data,
	output int             fail_count,
	output int             pending,
	output int             kept_count,
	output int             dropped_count,
	output int             logs_closed,
	output int             evicted_count
);

	edff_pkg::key_t history_key [HISTORY_DEPTH];
	logic           history_used [HISTORY_DEPTH];
	int unsigned    oldest_slot;
	int unsigned    filled;
	logic           log_kept;
	edff_pkg::out_t verdict_q [$];

	function automatic edff_pkg::out_t filter_event(input edff_pkg::in_t ev);
		edff_pkg::key_t key;
		edff_pkg::out_t res;
		logic found;
		int unsigned slot;
		key = {ev.event_kind, ev.packet_number, ev.frame_stamp, ev.event_time};
		found = 1'b0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (history_used[i] && history_key[i] == key)
				found = 1'b1;
		end
		if (!found) begin
			if (filled < HISTORY_DEPTH) begin
				slot = (oldest_slot + filled) % HISTORY_DEPTH;
				filled++;
			end else begin
				slot = oldest_slot;
				oldest_slot = (oldest_slot + 1) % HISTORY_DEPTH;
				evicted_count++;
			end
			history_key[slot] = key;
			history_used[slot] = 1'b1;
			log_kept = 1'b1;
			kept_count++;
		end else begin
			dropped_count++;
		end
		res.keep = !found;
		res.log_has_kept = ev.last_in_log ? log_kept : 1'b0;
		if (ev.last_in_log) begin
			log_kept = 1'b0;
			logs_closed++;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		edff_pkg::out_t want;
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++)
				history_used[i] = 1'b0;
			oldest_slot = 0;
			filled = 0;
			log_kept = 1'b0;
			verdict_q.delete();
			pending = 0;
			kept_count = 0;
			dropped_count = 0;
			logs_closed = 0;
			evicted_count = 0;
		end else begin
			if (in_valid && in_ready)
				verdict_q.push_back(filter_event(in_data));
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result keep=%b log_has_kept=%b, none expected",
						$time, out_data.keep, out_data.log_has_kept);
				end else begin
					want = verdict_q.pop_front();
					if (out_data.keep !== want.keep) begin
						fail_count++;
						$display("%0t: keep mismatch, expected %b, got %b",
							$time, want.keep, out_data.keep);
					end
					if (out_data.log_has_kept !== want.log_has_kept) begin
						fail_count++;
						$display("%0t: log_has_kept mismatch, expected %b, got %b",
							$time, want.log_has_kept, out_data.log_has_kept);
					end
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for the event duplicate filter: resets the block, drives directed
// and random event streams with varying idle patterns and reports the verdict.
// Depends on edff_pkg, the filter core and edff_filter_checker.
module tb;

	localparam int DEPTH            = edff_pkg::HISTORY_DEPTH_DEF;
	localparam int RANDOM_PER_PHASE = 444;
	localparam int POOL_SIZE        = 1024;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	edff_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	edff_pkg::out_t out_data;

	int fail_count;
	int pending;
	int kept_count;
	int dropped_count;
	int logs_closed;
	int evicted_count;
	int send_idle_pct;
	int recv_idle_pct;
	int sent_count;

	edff_pkg::in_t sent_pool [$];

	event_duplicate_filter_fifo_history_core #(
		.HISTORY_DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	edff_filter_checker #(
		.HISTORY_DEPTH(DEPTH)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.kept_count   (kept_count),
		.dropped_count(dropped_count),
		.logs_closed  (logs_closed),
		.evicted_count(evicted_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic edff_pkg::in_t mk_event(input logic [31:0] stamp, input logic [63:0] etime,
			input logic [7:0] kind, input logic [15:0] pkt, input logic last);
		edff_pkg::in_t ev;
		ev.frame_stamp   = stamp;
		ev.event_time    = etime;
		ev.event_kind    = kind;
		ev.packet_number = pkt;
		ev.last_in_log   = last;
		return ev;
	endfunction

	function automatic edff_pkg::in_t random_event();
		edff_pkg::in_t ev;
		logic [$bits(edff_pkg::in_t)-1:0] raw;
		int pick;
		int n;
		int span;
		n = sent_pool.size();
		span = (n < 64) ? n : 64;
		pick = $urandom_range(99);
		if (n == 0 || pick < 45) begin
			ev.frame_stamp   = $urandom;
			ev.event_time    = {$urandom, $urandom};
			ev.event_kind    = 8'($urandom);
			ev.packet_number = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
		end else if (pick < 80) begin
			if ($urandom_range(9) < 7)
				ev = sent_pool[n - 1 - $urandom_range(span - 1)];
			else
				ev = sent_pool[$urandom_range(n - 1)];
		end else if (pick < 95) begin
			raw = sent_pool[$urandom_range(n - 1)];
			raw[$urandom_range($bits(edff_pkg::in_t) - 1, 1)] ^= 1'b1;
			ev = raw;
		end else begin
			ev.frame_stamp   = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
			ev.event_kind    = $urandom_range(1) ? 8'hff : 8'h00;
			ev.packet_number = $urandom_range(1) ? 16'hffff : 16'h0000;
			case ($urandom_range(3))
				0: ev.event_time = 64'sh0;
				1: ev.event_time = -64'sd1;
				2: ev.event_time = 64'sh8000_0000_0000_0000;
				default: ev.event_time = 64'sh7fff_ffff_ffff_ffff;
			endcase
		end
		ev.last_in_log = ($urandom_range(4) == 0);
		return ev;
	endfunction

	// Entered and left just after a falling edge, before anything is driven in that step.
	task automatic push_event(input edff_pkg::in_t ev);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= ev;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
		sent_pool.push_back(ev);
		if (sent_pool.size() > POOL_SIZE)
			void'(sent_pool.pop_front());
	endtask

	task automatic wait_drain();
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_count    = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: extreme keys, single-field differences and log endings.
		push_event(mk_event(32'h0, 64'h0, 8'h00, 16'h0000, 1'b0));
		push_event(mk_event(32'h0, 64'h0, 8'h00, 16'h0000, 1'b1));
		push_event(mk_event(32'h0, 64'h0, 8'h00, 16'h0000, 1'b1));
		push_event(mk_event(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff, 16'hffff, 1'b1));
		push_event(mk_event(32'h0, 64'h8000_0000_0000_0000, 8'h00, 16'h0000, 1'b0));
		push_event(mk_event(32'h0, 64'h7fff_ffff_ffff_ffff, 8'h00, 16'h0000, 1'b0));
		push_event(mk_event(32'h0, 64'h0, 8'h01, 16'h0000, 1'b0));
		push_event(mk_event(32'h0, 64'h0, 8'h00, 16'h0001, 1'b0));
		push_event(mk_event(32'h1, 64'h0, 8'h00, 16'h0000, 1'b0));
		push_event(mk_event(32'h0, 64'h1, 8'h00, 16'h0000, 1'b0));
		push_event(mk_event(32'h0, 64'h8000_0000_0000_0000, 8'h00, 16'h0000, 1'b1));
		push_event(mk_event(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 8'hff, 16'hffff, 1'b1));
		push_event(mk_event(32'h1234_5678, 64'h0000_0001_0000_0000, 8'h5a, 16'h0000, 1'b1));
		push_event(mk_event(32'h8000_0000, 64'h0, 8'h80, 16'h8000, 1'b0));
		push_event(mk_event(32'h8000_0000, 64'h0, 8'h80, 16'h8000, 1'b0));
		push_event(mk_event(32'h0000_8000, 64'h0000_0000_8000_0000, 8'h40, 16'h0080, 1'b1));
		push_event(mk_event(32'h8000_0000, 64'h0, 8'h80, 16'h8000, 1'b0));
		push_event(mk_event(32'h0, 64'h0, 8'h00, 16'h0000, 1'b1));
		in_valid <= 1'b0;
		wait_drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 55;
				end
				1: begin
					send_idle_pct = 55;
					recv_idle_pct = 8;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE)
				push_event(random_event());
			in_valid <= 1'b0;
			wait_drain();
		end

		repeat (16) @(negedge clk);
		$display("Sent %0d events under three idle patterns: %0d kept, %0d dropped as duplicates,",
			sent_count, kept_count, dropped_count);
		$display("%0d logs closed and %0d keys evicted from a history of %0d entries.",
			logs_closed, evicted_count, DEPTH);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[event_duplicate_filter_fifo_history_core.f]
src/edff_pkg.sv
src/edff_cell.sv
src/edff_or_tree.sv
src/event_duplicate_filter_fifo_history_core.sv
src/edff_checker.sv
sim/edff_filter_checker.sv
sim/tb.sv
